// ===== rtl/chm_pkg.sv =====
// shared types, constants and codes of the chained hash map
package chm_pkg;

    localparam int MAX_BUCKETS_DEF = 256;
    localparam int POOL_NODES_DEF  = 1024;
    localparam int KEY_BITS_DEF    = 32;
    localparam int VALUE_BITS_DEF  = 32;

    localparam int CFG_W    = 9;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int DIV_BITS = 4;

    localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 9'd256;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_LOOKUP = 2'd2
    } chm_func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_POOL_FULL = 2'd2
    } chm_status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_HEAD_RD,
        S_DISPATCH,
        S_ALLOC_RD,
        S_INS_WR,
        S_WALK,
        S_CMP,
        S_DEL_FREE,
        S_OUT
    } chm_state_t;

    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic div_step;
        logic head_rd;
        logic cap_head;
        logic alloc;
        logic alloc_rd;
        logic ins_wr;
        logic node_rd;
        logic advance;
        logic unlink;
        logic free_push;
        logic set_ok;
        logic set_full;
        logic cap_val;
        logic load_out;
    } chm_cmd_t;

    typedef struct packed {
        logic             clr_last;
        logic             div_last;
        logic [FUNC_W-1:0] func;
        logic             free_avail;
        logic             never_avail;
        logic             cur_is_node;
        logic             key_match;
    } chm_stat_t;

endpackage

// ===== rtl/chm_ram.sv =====
// generic single-write, single-read ram with registered read data
module chm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/chm_ctrl.sv =====
// control state machine of the chained hash map
module chm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  chm_pkg::chm_stat_t stat,
    output chm_pkg::chm_cmd_t  cmd
);

    chm_pkg::chm_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= chm_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            chm_pkg::S_CLEAR: begin
                if (stat.clr_last) state_next = chm_pkg::S_IDLE;
            end
            chm_pkg::S_IDLE: begin
                if (s_tvalid) state_next = chm_pkg::S_DIV;
            end
            chm_pkg::S_DIV: begin
                if (stat.div_last) state_next = chm_pkg::S_HEAD_RD;
            end
            chm_pkg::S_HEAD_RD: state_next = chm_pkg::S_DISPATCH;
            chm_pkg::S_DISPATCH: begin
                if (stat.func == chm_pkg::FN_INSERT) begin
                    if (stat.free_avail) state_next = chm_pkg::S_ALLOC_RD;
                    else if (stat.never_avail) state_next = chm_pkg::S_INS_WR;
                    else state_next = chm_pkg::S_OUT;
                end else if (stat.func inside {chm_pkg::FN_DELETE, chm_pkg::FN_LOOKUP}) begin
                    state_next = chm_pkg::S_WALK;
                end else begin
                    state_next = chm_pkg::S_OUT;
                end
            end
            chm_pkg::S_ALLOC_RD: state_next = chm_pkg::S_INS_WR;
            chm_pkg::S_INS_WR:   state_next = chm_pkg::S_OUT;
            chm_pkg::S_WALK: begin
                state_next = stat.cur_is_node ? chm_pkg::S_CMP : chm_pkg::S_OUT;
            end
            chm_pkg::S_CMP: begin
                if (!stat.key_match) state_next = chm_pkg::S_WALK;
                else if (stat.func == chm_pkg::FN_DELETE) state_next = chm_pkg::S_DEL_FREE;
                else state_next = chm_pkg::S_OUT;
            end
            chm_pkg::S_DEL_FREE: state_next = chm_pkg::S_OUT;
            chm_pkg::S_OUT: begin
                if (slot_free) state_next = chm_pkg::S_IDLE;
            end
            default: state_next = chm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_tready = 1'b0;
        case (state_reg)
            chm_pkg::S_CLEAR: cmd.clr_wr = 1'b1;
            chm_pkg::S_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            chm_pkg::S_DIV:     cmd.div_step = 1'b1;
            chm_pkg::S_HEAD_RD: cmd.head_rd  = 1'b1;
            chm_pkg::S_DISPATCH: begin
                cmd.cap_head = 1'b1;
                if (stat.func == chm_pkg::FN_INSERT) begin
                    cmd.alloc    = 1'b1;
                    cmd.set_full = !stat.free_avail && !stat.never_avail;
                end
            end
            chm_pkg::S_ALLOC_RD: cmd.alloc_rd = 1'b1;
            chm_pkg::S_INS_WR: begin
                cmd.ins_wr = 1'b1;
                cmd.set_ok = 1'b1;
            end
            chm_pkg::S_WALK: cmd.node_rd = stat.cur_is_node;
            chm_pkg::S_CMP: begin
                if (stat.key_match) begin
                    cmd.set_ok  = 1'b1;
                    cmd.cap_val = (stat.func == chm_pkg::FN_LOOKUP);
                    cmd.unlink  = (stat.func == chm_pkg::FN_DELETE);
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            chm_pkg::S_DEL_FREE: cmd.free_push = 1'b1;
            chm_pkg::S_OUT:      cmd.load_out  = slot_free;
            default: cmd = '0;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
    end

    assign m_tvalid = out_valid_reg;

`ifndef SYNTH
    a_accept_to_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> state_reg == chm_pkg::S_DIV)
        else $error("accepted transaction did not start the bucket division");
    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == chm_pkg::S_CLEAR |-> !s_tready)
        else $error("input taken during bucket clearing");
    a_load_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result overwritten before it was taken");
    a_result_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_tvalid)
        else $error("loaded result not presented");
`endif

endmodule

// ===== rtl/chm_dp.sv =====
// datapath of the chained hash map: divider, pointers, memories, result
module chm_dp #(
    parameter int MAX_BUCKETS = chm_pkg::MAX_BUCKETS_DEF,
    parameter int POOL_NODES  = chm_pkg::POOL_NODES_DEF,
    parameter int KEY_BITS    = chm_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = chm_pkg::VALUE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [chm_pkg::CFG_W-1:0]      bucket_count,
    input  logic [chm_pkg::FUNC_W-1:0]     in_func,
    input  logic [KEY_BITS-1:0]            in_key,
    input  logic [VALUE_BITS-1:0]          in_value,
    input  chm_pkg::chm_cmd_t              cmd,
    output chm_pkg::chm_stat_t             stat,
    output logic [chm_pkg::STATUS_W-1:0]   out_status,
    output logic [VALUE_BITS-1:0]          out_value
);

    localparam int NW       = $clog2(POOL_NODES + 1);
    localparam int NAW      = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int BAW      = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int CW       = chm_pkg::CFG_W;
    localparam int DB       = chm_pkg::DIV_BITS;
    localparam int KPW      = ((KEY_BITS + DB - 1) / DB) * DB;
    localparam int DSTEPS   = KPW / DB;
    localparam int DCW      = $clog2(DSTEPS) + 1;
    localparam logic [NW-1:0] NO_NODE = NW'(POOL_NODES);

    logic [chm_pkg::FUNC_W-1:0] func_reg;
    logic [KEY_BITS-1:0]        key_reg;
    logic [VALUE_BITS-1:0]      value_reg;
    logic [KPW-1:0]             key_sh_reg;
    logic [CW-1:0]              div_reg;
    logic [CW-1:0]              rem_reg, rem_next;
    logic [DCW-1:0]             dcnt_reg;
    logic [BAW-1:0]             clr_reg;
    logic [NW-1:0]              cur_reg, prev_reg, alloc_reg;
    logic                       from_free_reg;
    logic [NW-1:0]              free_head_reg, never_used_reg;
    logic [chm_pkg::STATUS_W-1:0] st_reg;
    logic [VALUE_BITS-1:0]      res_reg;
    logic [chm_pkg::STATUS_W-1:0] out_status_reg;
    logic [VALUE_BITS-1:0]      out_value_reg;

    logic [CW-1:0]   divisor;
    logic [BAW-1:0]  bucket;
    logic            free_avail, never_avail;

    logic            head_we, head_re;
    logic [BAW-1:0]  head_waddr;
    logic [NW-1:0]   head_wdata, head_rdata;
    logic            link_we, link_re;
    logic [NAW-1:0]  link_waddr, link_raddr;
    logic [NW-1:0]   link_wdata, link_rdata;
    logic [KEY_BITS-1:0]   key_rdata;
    logic [VALUE_BITS-1:0] val_rdata;

    // effective divisor: zero means one, saturate at the bucket array size
    always_comb begin
        if (bucket_count == '0) divisor = CW'(1);
        else if (32'(bucket_count) > 32'(MAX_BUCKETS)) divisor = CW'(MAX_BUCKETS);
        else divisor = bucket_count;
    end

    // restoring remainder, DB key bits per cycle
    always_comb begin
        logic [CW:0] r;
        r = {1'b0, rem_reg};
        for (int i = 0; i < DB; i++) begin
            r = {r[CW-1:0], key_sh_reg[KPW-1-i]};
            if (r >= {1'b0, div_reg}) r = r - {1'b0, div_reg};
        end
        rem_next = r[CW-1:0];
    end

    assign bucket      = BAW'(rem_reg);
    assign free_avail  = free_head_reg != NO_NODE;
    assign never_avail = never_used_reg < NO_NODE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg        <= '0;
            free_head_reg  <= NO_NODE;
            never_used_reg <= '0;
        end else begin
            if (cmd.clr_wr) clr_reg <= clr_reg + BAW'(1);
            if (cmd.alloc && !free_avail && never_avail) begin
                never_used_reg <= never_used_reg + NW'(1);
            end
            if (cmd.ins_wr && from_free_reg) free_head_reg <= link_rdata;
            if (cmd.free_push) free_head_reg <= cur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg   <= in_func;
            key_reg    <= in_key;
            value_reg  <= in_value;
            key_sh_reg <= KPW'(in_key);
            div_reg    <= divisor;
            rem_reg    <= '0;
            dcnt_reg   <= '0;
            st_reg     <= chm_pkg::ST_NOT_FOUND;
            res_reg    <= '0;
        end
        if (cmd.div_step) begin
            rem_reg    <= rem_next;
            key_sh_reg <= key_sh_reg << DB;
            dcnt_reg   <= dcnt_reg + DCW'(1);
        end
        if (cmd.cap_head) begin
            cur_reg  <= head_rdata;
            prev_reg <= NO_NODE;
        end
        if (cmd.alloc) begin
            alloc_reg     <= free_avail ? free_head_reg : never_used_reg;
            from_free_reg <= free_avail;
        end
        if (cmd.advance) begin
            prev_reg <= cur_reg;
            cur_reg  <= link_rdata;
        end
        if (cmd.set_ok)   st_reg  <= chm_pkg::ST_OK;
        if (cmd.set_full) st_reg  <= chm_pkg::ST_POOL_FULL;
        if (cmd.cap_val)  res_reg <= val_rdata;
        if (cmd.load_out) begin
            out_status_reg <= st_reg;
            out_value_reg  <= res_reg;
        end
    end

    // bucket head writes: clearing sweep, insert at head, unlink of first node
    always_comb begin
        head_we    = cmd.clr_wr || cmd.ins_wr || (cmd.unlink && prev_reg == NO_NODE);
        head_waddr = cmd.clr_wr ? clr_reg : bucket;
        head_wdata = NO_NODE;
        if (cmd.ins_wr) head_wdata = alloc_reg;
        else if (cmd.unlink) head_wdata = link_rdata;
        head_re = cmd.head_rd;
    end

    always_comb begin
        link_we    = cmd.ins_wr || cmd.free_push || (cmd.unlink && prev_reg != NO_NODE);
        link_waddr = cur_reg[NAW-1:0];
        link_wdata = free_head_reg;
        if (cmd.ins_wr) begin
            link_waddr = alloc_reg[NAW-1:0];
            link_wdata = cur_reg;
        end else if (cmd.unlink) begin
            link_waddr = prev_reg[NAW-1:0];
            link_wdata = link_rdata;
        end
        link_re    = cmd.alloc_rd || cmd.node_rd;
        link_raddr = cmd.alloc_rd ? alloc_reg[NAW-1:0] : cur_reg[NAW-1:0];
    end

    chm_ram #(.WIDTH(NW), .DEPTH(MAX_BUCKETS)) u_heads (
        .aclk  (aclk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (head_re),
        .raddr (bucket),
        .rdata (head_rdata)
    );

    chm_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_links (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    chm_ram #(.WIDTH(KEY_BITS), .DEPTH(POOL_NODES)) u_keys (
        .aclk  (aclk),
        .we    (cmd.ins_wr),
        .waddr (alloc_reg[NAW-1:0]),
        .wdata (key_reg),
        .re    (cmd.node_rd),
        .raddr (cur_reg[NAW-1:0]),
        .rdata (key_rdata)
    );

    chm_ram #(.WIDTH(VALUE_BITS), .DEPTH(POOL_NODES)) u_values (
        .aclk  (aclk),
        .we    (cmd.ins_wr),
        .waddr (alloc_reg[NAW-1:0]),
        .wdata (value_reg),
        .re    (cmd.node_rd),
        .raddr (cur_reg[NAW-1:0]),
        .rdata (val_rdata)
    );

    always_comb begin
        stat.clr_last    = clr_reg == BAW'(MAX_BUCKETS - 1);
        stat.div_last    = dcnt_reg == DCW'(DSTEPS - 1);
        stat.func        = func_reg;
        stat.free_avail  = free_avail;
        stat.never_avail = never_avail;
        stat.cur_is_node = cur_reg != NO_NODE;
        stat.key_match   = key_rdata == key_reg;
    end

    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.head_rd |-> rem_reg < div_reg)
        else $error("bucket index not below divisor");
    a_alloc_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_wr |-> alloc_reg < NO_NODE)
        else $error("insert into a node outside the pool");
    a_never_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        never_used_reg <= NO_NODE)
        else $error("never-used counter ran past the pool");
`endif

endmodule

// ===== rtl/chained_hash_map.sv =====
// top level of the chained hash map: stream ports, register port, submodules
// Key-to-value map with separate chaining. Each transaction is an insert, delete or lookup
// (any other function code gives not found) and yields one result. The bucket index is the
// key modulo bucket_count (zero taken as one, capped at MAX_BUCKETS), worked out four key
// bits per cycle; then the bucket head is fetched, and each chain node visited is first read
// from memory and then compared. After reset all MAX_BUCKETS bucket heads are cleared in
// a pass during which no input is taken. Change bucket_count only while the block is idle.
module chained_hash_map #(
    parameter int MAX_BUCKETS = chm_pkg::MAX_BUCKETS_DEF,
    parameter int POOL_NODES  = chm_pkg::POOL_NODES_DEF,
    parameter int KEY_BITS    = chm_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = chm_pkg::VALUE_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    // func, key, value
    input  logic [((chm_pkg::FUNC_W + KEY_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic s_tvalid,
    output logic s_tready,
    // status, found_value
    output logic [((chm_pkg::STATUS_W + VALUE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int OUT_W = ((chm_pkg::STATUS_W + VALUE_BITS + 7) / 8) * 8;
    localparam int FW    = chm_pkg::FUNC_W;

    logic [chm_pkg::CFG_W-1:0] bucket_count_reg;
    logic                      reg_hit;
    chm_pkg::chm_cmd_t  cmd;
    chm_pkg::chm_stat_t stat;
    logic [chm_pkg::STATUS_W-1:0] out_status;
    logic [VALUE_BITS-1:0]        out_value;

    assign pready  = 1'b1;
    assign reg_hit = paddr[2] == 1'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= chm_pkg::BUCKET_COUNT_RST;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            bucket_count_reg <= pwdata[chm_pkg::CFG_W-1:0];
        end
    end

    assign prdata = reg_hit ? 32'(bucket_count_reg) : 32'd0;

    chm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    chm_dp #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .POOL_NODES  (POOL_NODES),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .bucket_count (bucket_count_reg),
        .in_func      (s_tdata[FW-1:0]),
        .in_key       (s_tdata[FW +: KEY_BITS]),
        .in_value     (s_tdata[FW + KEY_BITS +: VALUE_BITS]),
        .cmd          (cmd),
        .stat         (stat),
        .out_status   (out_status),
        .out_value    (out_value)
    );

    assign m_tdata = OUT_W'({out_value, out_status});

endmodule

// ===== sim/chm_checker.sv =====
// checker for the chained hash map: predicts every result and compares it
`timescale 1ns / 100ps

module chm_checker #(
    parameter int SW = 72,
    parameter int MW = 40
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [SW-1:0] s_tdata,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [MW-1:0] m_tdata,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic          pready,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output int            errors,
    output int            pending,
    output int            n_full
);

    localparam int NBUCK = chm_pkg::MAX_BUCKETS_DEF;
    localparam int NPOOL = chm_pkg::POOL_NODES_DEF;
    localparam int NONE  = NPOOL;
    localparam logic [2:0] ADDR_BUCKET_COUNT = 3'd0;

    typedef struct {
        logic [chm_pkg::STATUS_W-1:0] status;
        logic [31:0]                  found_value;
    } chm_result_t;

    chm_result_t result_q[$];

    logic [chm_pkg::CFG_W-1:0] buckets_cfg;
    int               heads[NBUCK];
    logic [31:0]      keys[NPOOL];
    logic [31:0]      vals[NPOOL];
    int               links[NPOOL];
    int               free_head;
    int               fresh_next;

    task automatic predict_op(input logic [chm_pkg::FUNC_W-1:0] fn, input logic [31:0] k,
                              input logic [31:0] v);
        int          nb;
        int          b;
        int          cur;
        int          prev;
        int          n;
        chm_result_t r;
        nb = (buckets_cfg == 0) ? 1 : (buckets_cfg > NBUCK) ? NBUCK : int'(buckets_cfg);
        b = int'(k % nb);
        r.status = chm_pkg::ST_NOT_FOUND;
        r.found_value = '0;
        if (fn == chm_pkg::FN_INSERT) begin
            n = NONE;
            if (free_head != NONE) begin
                n = free_head;
                free_head = links[n];
            end else if (fresh_next < NPOOL) begin
                n = fresh_next;
                fresh_next++;
            end
            if (n != NONE) begin
                keys[n] = k;
                vals[n] = v;
                links[n] = heads[b];
                heads[b] = n;
                r.status = chm_pkg::ST_OK;
            end else begin
                r.status = chm_pkg::ST_POOL_FULL;
            end
        end else if (fn == chm_pkg::FN_DELETE || fn == chm_pkg::FN_LOOKUP) begin
            prev = NONE;
            cur = heads[b];
            while (cur != NONE) begin
                if (keys[cur] == k) begin
                    r.status = chm_pkg::ST_OK;
                    if (fn == chm_pkg::FN_LOOKUP) begin
                        r.found_value = vals[cur];
                    end else begin
                        if (prev != NONE) links[prev] = links[cur];
                        else heads[b] = links[cur];
                        links[cur] = free_head;
                        free_head = cur;
                    end
                    break;
                end
                prev = cur;
                cur = links[cur];
            end
        end
        result_q.push_back(r);
    endtask

    always @(posedge aclk) begin
        chm_result_t e;
        if (!aresetn) begin
            result_q.delete();
            buckets_cfg = chm_pkg::BUCKET_COUNT_RST;
            for (int i = 0; i < NBUCK; i++) heads[i] = NONE;
            free_head = NONE;
            fresh_next = 0;
            errors = 0;
            n_full = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_BUCKET_COUNT)
                buckets_cfg = pwdata[chm_pkg::CFG_W-1:0];
            if (s_tvalid && s_tready)
                predict_op(s_tdata[1:0], s_tdata[33:2], s_tdata[65:34]);
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    errors++;
                end else begin
                    e = result_q.pop_front();
                    if (e.status == chm_pkg::ST_POOL_FULL) n_full++;
                    if (m_tdata[1:0] !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, m_tdata[1:0]);
                        errors++;
                    end
                    if (m_tdata[33:2] !== e.found_value) begin
                        $error("found_value: expected %h, got %h", e.found_value,
                               m_tdata[33:2]);
                        errors++;
                    end
                end
            end
        end
        pending = result_q.size();
    end

endmodule

// ===== sim/tb_chained_hash_map.sv =====
// testbench top for the chained hash map: stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb_chained_hash_map;

    localparam int SW = ((chm_pkg::FUNC_W + chm_pkg::KEY_BITS_DEF +
                          chm_pkg::VALUE_BITS_DEF + 7) / 8) * 8;
    localparam int MW = ((chm_pkg::STATUS_W + chm_pkg::VALUE_BITS_DEF + 7) / 8) * 8;
    localparam logic [chm_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;
    localparam logic [2:0] ADDR_BUCKET_COUNT = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED     = 3'd4;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 300;

    logic          aclk = 1'b0;
    logic          aresetn;
    logic [SW-1:0] s_tdata;
    logic          s_tvalid;
    logic          s_tready;
    logic [MW-1:0] m_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    int errors;
    int pending;
    int n_full;
    int n_ops;
    int n_settings;
    int idle_cnt;
    bit no_gaps;
    bit hold_req;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    chained_hash_map dut (.*);

    chm_checker #(.SW(SW), .MW(MW)) u_checker (.*);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            stall = no_gaps ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_op(input logic [chm_pkg::FUNC_W-1:0] fn, input logic [31:0] k,
                           input logic [31:0] v);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(SW - 66){1'b0}}, v, k, fn};
        do @(posedge aclk); while (!s_tready);
        n_ops++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        if (addr == ADDR_BUCKET_COUNT) n_settings++;
    endtask

    function automatic logic [chm_pkg::FUNC_W-1:0] pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return chm_pkg::FN_INSERT;
        if (r < 65) return chm_pkg::FN_DELETE;
        if (r < 95) return chm_pkg::FN_LOOKUP;
        return FN_UNUSED;
    endfunction

    initial begin
        logic [31:0] key_set[12];
        logic [31:0] recent[$];
        logic [31:0] k;
        int settings[8];
        settings = '{1, 7, 511, 0, 13, 256, 2, 100};
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        no_gaps = 1'b0;
        hold_req = 1'b0;
        n_ops = 0;
        n_settings = 0;
        idle_cnt = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: misses, extremes, duplicates, unlink at head and middle, reuse
        send_op(chm_pkg::FN_LOOKUP, 32'd5, 32'd0);
        send_op(chm_pkg::FN_DELETE, 32'd5, 32'd0);
        send_op(FN_UNUSED, 32'd5, 32'hFFFF_FFFF);
        send_op(chm_pkg::FN_INSERT, 32'd0, 32'd0);
        send_op(chm_pkg::FN_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(chm_pkg::FN_LOOKUP, 32'hFFFF_FFFF, 32'd0);
        send_op(chm_pkg::FN_INSERT, 32'd256, 32'd1);
        send_op(chm_pkg::FN_INSERT, 32'd0, 32'd2);
        send_op(chm_pkg::FN_LOOKUP, 32'd0, 32'd0);
        send_op(chm_pkg::FN_DELETE, 32'd0, 32'd0);
        send_op(chm_pkg::FN_LOOKUP, 32'd0, 32'd0);
        send_op(chm_pkg::FN_DELETE, 32'd0, 32'd0);
        send_op(chm_pkg::FN_LOOKUP, 32'd0, 32'd0);
        send_op(chm_pkg::FN_LOOKUP, 32'd256, 32'd0);
        send_op(chm_pkg::FN_INSERT, 32'd512, 32'd3);
        send_op(chm_pkg::FN_INSERT, 32'd768, 32'd4);
        send_op(chm_pkg::FN_DELETE, 32'd512, 32'd0);
        send_op(chm_pkg::FN_LOOKUP, 32'd768, 32'd0);
        send_op(chm_pkg::FN_LOOKUP, 32'd256, 32'd0);
        send_op(chm_pkg::FN_DELETE, 32'hFFFF_FFFF, 32'd0);
        send_op(chm_pkg::FN_INSERT, 32'd7, 32'hAAAA_5555);
        send_op(chm_pkg::FN_LOOKUP, 32'd7, 32'd0);
        drain();
        reg_write(ADDR_UNMAPPED, 32'd3);

        // random phases over several bucket counts, old chains kept across changes
        foreach (settings[p]) begin
            reg_write(ADDR_BUCKET_COUNT, settings[p]);
            foreach (key_set[i]) key_set[i] = (i == 0) ? 32'hFFFF_FFFF : $urandom();
            no_gaps = (p == 2);
            for (int i = 0; i < 70; i++) begin
                if (p == 1 && i == 40) hold_req = 1'b1;
                k = ($urandom_range(0, 19) == 0) ? $urandom() :
                    key_set[$urandom_range(0, 11)];
                send_op(pick_func(), k, $urandom());
            end
            drain();
        end

        // fill more nodes, free some of them and reuse them from the free list
        reg_write(ADDR_BUCKET_COUNT, 32'd256);
        no_gaps = 1'b1;
        for (int i = 0; i < 60; i++) begin
            k = $urandom();
            if (recent.size() < 30) recent.push_back(k);
            send_op(chm_pkg::FN_INSERT, k, $urandom());
        end
        no_gaps = 1'b0;
        foreach (recent[i]) send_op(chm_pkg::FN_DELETE, recent[i], 32'd0);
        for (int i = 0; i < 35; i++) send_op(chm_pkg::FN_INSERT, recent[i % 30], $urandom());
        foreach (recent[i]) send_op(chm_pkg::FN_LOOKUP, recent[i], 32'd0);
        drain();

        $display("%0d operations over %0d bucket-count settings, %0d pool-full results",
                 n_ops, n_settings, n_full);
        $display("directed chain edits, random mixes, a long output stall, free-list reuse");
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/chm_pkg.sv
rtl/chm_ram.sv
rtl/chm_ctrl.sv
rtl/chm_dp.sv
rtl/chained_hash_map.sv
sim/chm_checker.sv
sim/tb_chained_hash_map.sv
